>>> sv/lifo_handle_list_unit_defines.svh
// Assertion macros shared by the handle list modules.
`ifndef LIFO_HANDLE_LIST_UNIT_DEFINES_SVH
`define LIFO_HANDLE_LIST_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LHL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LHL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define LHL_ASSERT(label, prop, msg)
`define LHL_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

>>> sv/lhl_pkg.sv
// Types and codes shared by the handle list modules.
`timescale 1ns / 1ps
`default_nettype none
package lhl_pkg;

   localparam int OP_W     = 3;
   localparam int HANDLE_W = 32;
   localparam int POS_W    = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
   localparam logic [OP_W-1:0] OP_PULL     = 3'd1;
   localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK     = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;
   localparam logic [OP_W-1:0] OP_LENGTH   = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd5;

   localparam logic [2:0] RD_HEAD = 3'd0;
   localparam logic [2:0] RD_PEEK = 3'd1;
   localparam logic [2:0] RD_DOWN = 3'd2;
   localparam logic [2:0] RD_UP   = 3'd3;
   localparam logic [2:0] RD_UP2  = 3'd4;

   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_PUSH  = 2'd1;
   localparam logic [1:0] WR_SHIFT = 2'd2;

   localparam logic [1:0] IDX_HOLD = 2'd0;
   localparam logic [1:0] IDX_HEAD = 2'd1;
   localparam logic [1:0] IDX_DEC  = 2'd2;
   localparam logic [1:0] IDX_INC  = 2'd3;

   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_CLR  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [HANDLE_W-1:0] item_handle;
      logic [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] read_handle;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic                rd_en;
      logic [2:0]          rd_sel;
      logic [1:0]          wr_sel;
      logic [1:0]          idx_op;
      logic [1:0]          cnt_op;
      logic                res_load;
      logic [STATUS_W-1:0] res_status;
      logic                res_take;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            out_of_range;
      logic            match;
      logic            idx_zero;
      logic            idx_top;
      logic            shift_done;
      logic            out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> sv/lhl_datapath.sv
// Datapath of the handle list: entry memory, count, walk index and result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_handle_list_unit_defines.svh"
module lhl_datapath #(
   parameter int DEPTH       = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  lhl_pkg::req_type req_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output lhl_pkg::rsp_type rsp_data,
   input  lhl_pkg::cmd_type cmd,
   output lhl_pkg::sts_type sts
);

   localparam int KEEP = (HANDLE_BITS < lhl_pkg::HANDLE_W) ? HANDLE_BITS : lhl_pkg::HANDLE_W;
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);

   logic [KEEP-1:0] mem [DEPTH];

   logic [lhl_pkg::OP_W-1:0]     op_ff;
   logic [KEEP-1:0]              handle_ff;
   logic [lhl_pkg::POS_W-1:0]    pos_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [KEEP-1:0]              rd_data_ff;
   logic [lhl_pkg::STATUS_W-1:0] res_status_ff;
   logic [lhl_pkg::HANDLE_W-1:0] res_handle_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lhl_pkg::rsp_type             rsp_data_ff;

   logic [CW-1:0]   head_c;
   logic [AW-1:0]   head_a;
   logic [AW-1:0]   peek_a;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [KEEP-1:0] wr_data;

   assign head_c = count_ff - CW'(1);
   assign head_a = head_c[AW-1:0];
   assign peek_a = head_a - pos_ff[AW-1:0];

   always_comb begin
      case (cmd.rd_sel)
         lhl_pkg::RD_HEAD: rd_addr = head_a;
         lhl_pkg::RD_PEEK: rd_addr = peek_a;
         lhl_pkg::RD_DOWN: rd_addr = idx_ff - AW'(1);
         lhl_pkg::RD_UP:   rd_addr = idx_ff + AW'(1);
         lhl_pkg::RD_UP2:  rd_addr = idx_ff + AW'(2);
         default:          rd_addr = head_a;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         lhl_pkg::WR_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[AW-1:0];
            wr_data = handle_ff;
         end
         lhl_pkg::WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         lhl_pkg::CNT_INC: count_in = count_ff + CW'(1);
         lhl_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         lhl_pkg::CNT_CLR: count_in = '0;
         default:          count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.idx_op)
         lhl_pkg::IDX_HEAD: idx_in = head_a;
         lhl_pkg::IDX_DEC:  idx_in = idx_ff - AW'(1);
         lhl_pkg::IDX_INC:  idx_in = idx_ff + AW'(1);
         default:           idx_in = idx_ff;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff     <= req_data.operation;
         handle_ff <= req_data.item_handle[KEEP-1:0];
         pos_ff    <= req_data.position;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_handle_ff <= cmd.res_take ? lhl_pkg::HANDLE_W'(rd_data_ff) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.status      <= res_status_ff;
         rsp_data_ff.read_handle <= res_handle_ff;
         rsp_data_ff.entry_count <= lhl_pkg::COUNT_W'(count_ff);
      end
   end

   assign sts.op           = op_ff;
   assign sts.empty        = (count_ff == '0);
   assign sts.full         = (count_ff == CW'(DEPTH));
   assign sts.out_of_range = (pos_ff >= lhl_pkg::POS_W'(count_ff));
   assign sts.match        = (rd_data_ff == handle_ff);
   assign sts.idx_zero     = (idx_ff == '0);
   assign sts.idx_top      = (idx_ff == head_a);
   assign sts.shift_done   = ((idx_ff + AW'(1)) == head_a);
   assign sts.out_free     = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LHL_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "entry count above depth")
   `LHL_ASSERT_IMPL(a_count_step, count_ff != $past(count_ff), count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1) || count_ff == '0, "entry count jumped")

endmodule
`default_nettype wire

>>> sv/lhl_controller.sv
// Controller state machine that sequences each operation over the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_handle_list_unit_defines.svh"
module lhl_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lhl_pkg::sts_type sts,
   output lhl_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE        = 3'd0;
   localparam logic [2:0] S_EXEC        = 3'd1;
   localparam logic [2:0] S_READ        = 3'd2;
   localparam logic [2:0] S_SCAN        = 3'd3;
   localparam logic [2:0] S_SHIFT_START = 3'd4;
   localparam logic [2:0] S_SHIFT       = 3'd5;
   localparam logic [2:0] S_DONE        = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_sel     = lhl_pkg::RD_HEAD;
      cmd.wr_sel     = lhl_pkg::WR_NONE;
      cmd.idx_op     = lhl_pkg::IDX_HOLD;
      cmd.cnt_op     = lhl_pkg::CNT_HOLD;
      cmd.res_load   = 1'b0;
      cmd.res_status = lhl_pkg::ST_OK;
      cmd.res_take   = 1'b0;
      cmd.rsp_load   = 1'b0;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               cmd.idx_op = lhl_pkg::IDX_HEAD;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_DONE;
            cmd.res_load = 1'b1;
            case (sts.op)
               lhl_pkg::OP_PUSH: begin
                  if (sts.full) begin
                     cmd.res_status = lhl_pkg::ST_FULL;
                  end else begin
                     cmd.wr_sel = lhl_pkg::WR_PUSH;
                     cmd.cnt_op = lhl_pkg::CNT_INC;
                  end
               end
               lhl_pkg::OP_PULL: begin
                  if (sts.empty) begin
                     cmd.res_status = lhl_pkg::ST_EMPTY;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd_en    = 1'b1;
                     state_in     = S_READ;
                  end
               end
               lhl_pkg::OP_CONTAINS, lhl_pkg::OP_REMOVE: begin
                  if (sts.empty) begin
                     cmd.res_status = lhl_pkg::ST_EMPTY;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd_en    = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               lhl_pkg::OP_PEEK: begin
                  if (sts.empty) begin
                     cmd.res_status = lhl_pkg::ST_EMPTY;
                  end else if (sts.out_of_range) begin
                     cmd.res_status = lhl_pkg::ST_RANGE;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = lhl_pkg::RD_PEEK;
                     state_in     = S_READ;
                  end
               end
               lhl_pkg::OP_CLEAR: begin
                  cmd.cnt_op = lhl_pkg::CNT_CLR;
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_take = 1'b1;
            if (sts.op == lhl_pkg::OP_PULL) begin
               cmd.cnt_op = lhl_pkg::CNT_DEC;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lhl_pkg::RD_DOWN;
            if (sts.match) begin
               if (sts.op == lhl_pkg::OP_CONTAINS) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = lhl_pkg::ST_FOUND;
                  state_in       = S_DONE;
               end else if (sts.idx_top) begin
                  cmd.res_load = 1'b1;
                  cmd.cnt_op   = lhl_pkg::CNT_DEC;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_SHIFT_START;
               end
            end else if (sts.idx_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = lhl_pkg::ST_NOT_FOUND;
               state_in       = S_DONE;
            end else begin
               cmd.idx_op = lhl_pkg::IDX_DEC;
            end
         end
         S_SHIFT_START: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lhl_pkg::RD_UP;
            state_in   = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.wr_sel = lhl_pkg::WR_SHIFT;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lhl_pkg::RD_UP2;
            if (sts.shift_done) begin
               cmd.res_load = 1'b1;
               cmd.cnt_op   = lhl_pkg::CNT_DEC;
               state_in     = S_DONE;
            end else begin
               cmd.idx_op = lhl_pkg::IDX_INC;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LHL_ASSERT_IMPL(a_rsp_free, cmd.rsp_load, sts.out_free, "result overwritten before taken")
   `LHL_ASSERT_IMPL(a_push_room, cmd.wr_sel == lhl_pkg::WR_PUSH, !sts.full, "push write when full")
   `LHL_ASSERT(a_accept_exec, (state_ff == S_IDLE && req_valid) |=> (state_ff == S_EXEC), "accepted beat not executed")

endmodule
`default_nettype wire

>>> sv/lifo_handle_list_unit.sv
// Push, clear, length and rejected ops go from the execute state straight to the result beat.
// Pull and peek pass through a read state after execute; the entry memory read is registered.
// Contains walks the list, one entry compared per cycle from the head down.
// Remove does the search walk, then moves one entry per cycle.
// One request in flight; the next is taken after its result is loaded.
// Reset clears the entry count and control state; the entry memory keeps its contents.
`timescale 1ns / 1ps
`default_nettype none
module lifo_handle_list_unit #(
   parameter int DEPTH       = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lhl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lhl_pkg::rsp_type rsp_data
);

   lhl_pkg::cmd_type cmd;
   lhl_pkg::sts_type sts;

   lhl_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lhl_datapath #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire
